// File: rtl/core/mcpt_pkg.sv
// Shared types and constants for the multi-channel pulse timer.
// No dependencies; imported by mcpt_chan_bank and multi_channel_pulse_timer.
`default_nettype none

package mcpt_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CMD_W        = 2;
  localparam int CHAN_W       = 6;
  localparam int DUR_W        = 16;
  localparam int MASK_W       = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_FIRE_ONE = 2'd1,
    CMD_FIRE_ALL = 2'd2,
    CMD_ABORT    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAN_W-1:0] channel;
    logic [DUR_W-1:0]  duration_ms;
  } cmd_word_t;

  typedef struct packed {
    logic              ok;
    logic [MASK_W-1:0] armed_mask;
    logic [MASK_W-1:0] pin_mask;
  } result_word_t;

endpackage

`default_nettype wire

// File: rtl/core/mcpt_chan_bank.sv
// Channel state bank: armed bits, down-counters and pin levels for all channels.
// Depends on mcpt_pkg; applies one command word per enabled cycle and reports the result.
`default_nettype none

module mcpt_chan_bank (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  upd_en,
  input  wire mcpt_pkg::cmd_word_t   word,
  output      mcpt_pkg::result_word_t result
);
  import mcpt_pkg::*;

  logic                 armed_r     [NUM_CHANNELS];
  logic [DUR_W-1:0]     remaining_r [NUM_CHANNELS];
  logic                 pin_r       [NUM_CHANNELS];
  logic                 armed_nxt     [NUM_CHANNELS];
  logic [DUR_W-1:0]     remaining_nxt [NUM_CHANNELS];
  logic                 pin_nxt       [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] hit;
  logic                 chan_valid;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit[i] = (word.channel == CHAN_W'(i + 1));
    end
    chan_valid = |hit;
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      armed_nxt[i]     = armed_r[i];
      remaining_nxt[i] = remaining_r[i];
      pin_nxt[i]       = pin_r[i];
      unique case (word.cmd)
        CMD_TICK: begin
          if (armed_r[i]) begin
            if (remaining_r[i] == '0) begin
              armed_nxt[i] = 1'b0;
            end else begin
              remaining_nxt[i] = remaining_r[i] - DUR_W'(1);
            end
          end
          pin_nxt[i] = armed_nxt[i];
        end
        CMD_FIRE_ONE: begin
          if (hit[i]) begin
            armed_nxt[i]     = 1'b1;
            remaining_nxt[i] = word.duration_ms;
          end
        end
        CMD_FIRE_ALL: begin
          armed_nxt[i]     = 1'b1;
          remaining_nxt[i] = word.duration_ms;
        end
        CMD_ABORT: begin
          armed_nxt[i] = 1'b0;
        end
        default: begin
          armed_nxt[i] = armed_r[i];
        end
      endcase
    end
  end

  always_comb begin
    result.ok         = !((word.cmd == CMD_FIRE_ONE) && !chan_valid);
    result.armed_mask = '0;
    result.pin_mask   = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_CHANNELS) begin
        result.armed_mask[i] = armed_nxt[i];
        result.pin_mask[i]   = pin_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        armed_r[i]     <= 1'b0;
        remaining_r[i] <= '0;
        pin_r[i]       <= 1'b0;
      end else if (upd_en) begin
        armed_r[i]     <= armed_nxt[i];
        remaining_r[i] <= remaining_nxt[i];
        pin_r[i]       <= pin_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/multi_channel_pulse_timer.sv
// Top level of the multi-channel one-shot pulse timer: input register,
// channel bank and result register. Depends on mcpt_pkg and mcpt_chan_bank.
//
//   Channel | Ports                                  | Direction
//   --------+----------------------------------------+----------
//   in      | in_valid/in_ready, cmd, channel, dur   | input
//   out     | out_valid/out_ready, ok, armed, pin    | output
//
// A command word is registered on acceptance and its result word is then
// captured in the output register when the result side can take it.
// One word is accepted every cycle while the result side keeps up.
// Reset clears all channels and both stage valids.
// When the result is stalled, the input register holds and in_ready drops
// once it is full.
`default_nettype none

module multi_channel_pulse_timer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [mcpt_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [mcpt_pkg::CHAN_W-1:0]    in_channel,
  input  wire logic [mcpt_pkg::DUR_W-1:0]     in_duration_ms,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           out_ok,
  output      logic [mcpt_pkg::MASK_W-1:0]    out_armed_mask,
  output      logic [mcpt_pkg::MASK_W-1:0]    out_pin_mask
);
  import mcpt_pkg::*;

  logic         stg_valid_r;
  cmd_word_t    stg_word_r;
  logic         out_valid_r;
  result_word_t out_word_r;
  result_word_t bank_result;
  logic         advance;

  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  mcpt_chan_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .word   (stg_word_r),
    .result (bank_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      stg_word_r.cmd         <= cmd_t'(in_cmd);
      stg_word_r.channel     <= in_channel;
      stg_word_r.duration_ms <= in_duration_ms;
    end
    if (advance) begin
      out_word_r <= bank_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_word_r.ok;
  assign out_armed_mask = out_word_r.armed_mask;
  assign out_pin_mask   = out_word_r.pin_mask;

endmodule

`default_nettype wire
